### rtl/core/dsc_pkg.sv
// Package for the diffusion stencil coefficient block: table sizes, field widths,
// operation and status codes and the control record that travels down the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package dsc_pkg;

  // Table geometry.
  localparam int MAX_COLUMNS   = 16;
  localparam int MAX_ROWS      = 64;
  localparam int MAX_MATERIALS = 256;
  localparam int GROUPS        = 4;
  localparam int SIGMA_DEPTH   = MAX_MATERIALS * GROUPS;
  localparam int MAP_DEPTH     = MAX_COLUMNS * MAX_ROWS;
  localparam int RAD_DEPTH     = MAX_COLUMNS + 2;
  localparam int AX_DEPTH      = MAX_ROWS + 2;
  localparam int SIG_AW        = $clog2(SIGMA_DEPTH);
  localparam int MAP_AW        = $clog2(MAP_DEPTH);
  localparam int RAD_AW        = $clog2(RAD_DEPTH);
  localparam int AX_AW         = $clog2(AX_DEPTH);
  localparam int MAT_BITS      = $clog2(MAX_MATERIALS);
  localparam int GRP_BITS      = $clog2(GROUPS);

  // Item field widths.
  localparam int OP_W     = 3;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 4;
  localparam int CELL_W   = 10;
  localparam int GROUP_W  = 3;
  localparam int MID_W    = 9;
  localparam int ADDR_W   = 7;
  localparam int VAL_W    = 32;
  localparam int COEF_W   = 48;
  localparam int STATUS_W = 2;

  // Configuration registers.
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int COLS_CFG_W = 5;
  localparam int ROWS_CFG_W = 7;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 5'd16;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd35;
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Arithmetic widths.
  localparam int PROD_W    = 2 * VAL_W;
  localparam int TRIP_W    = 3 * VAL_W;
  localparam int SUM_W     = TRIP_W + 1;
  localparam int DEN_W     = SUM_W + 2;
  localparam int REM_W     = DEN_W + 1;
  localparam int Q_W       = COEF_W - 1;
  localparam int DIV_EXP   = 81;
  localparam int DIV_STEPS = Q_W;
  localparam logic [REM_W-1:0]  DIV_INIT = REM_W'(1) << (DIV_EXP - Q_W);
  localparam logic [DEN_W-1:0]  SAT_DEN  = DEN_W'(1) << (DIV_EXP - Q_W);
  localparam logic [COEF_W-1:0] SAT_COEF = {1'b1, {(COEF_W-1){1'b0}}};

  // Neighbor directions.
  localparam int DIR_E = 0;
  localparam int DIR_W = 1;
  localparam int DIR_N = 2;
  localparam int DIR_S = 3;
  localparam int NDIR  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SIGMA = 3'd0,
    OP_LOAD_MAT   = 3'd1,
    OP_LOAD_RAD   = 3'd2,
    OP_LOAD_AX    = 3'd3,
    OP_COMPUTE    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_WRITTEN  = 2'd1,
    ST_ZERO_DEN = 2'd2,
    ST_ID_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic    compute;
    status_t status;
  } ctrl_t;

endpackage

### rtl/core/dsc_if.sv
// Item channel interfaces for the diffusion stencil coefficient block.
// Depends on dsc_pkg for the field widths.
`timescale 1ns / 1ps

interface dsc_in_if;
  import dsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    column;
  logic [CELL_W-1:0]   cell_index;
  logic [GROUP_W-1:0]  group;
  logic [MID_W-1:0]    material_id;
  logic [ADDR_W-1:0]   table_address;
  logic [VAL_W-1:0]    value;
  modport source (output valid, op, row, column, cell_index, group, material_id,
                  table_address, value, input ready);
  modport sink (input valid, op, row, column, cell_index, group, material_id,
                table_address, value, output ready);
endinterface

interface dsc_out_if;
  import dsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_east;
  logic signed [COEF_W-1:0] coef_west;
  logic signed [COEF_W-1:0] coef_north;
  logic signed [COEF_W-1:0] coef_south;
  logic [STATUS_W-1:0]      status;
  modport source (output valid, coef_east, coef_west, coef_north, coef_south, status,
                  input ready);
  modport sink (input valid, coef_east, coef_west, coef_north, coef_south, status,
                output ready);
endinterface

### rtl/core/diffusion_stencil_coefficients.sv
// Top level of the diffusion stencil coefficient block: tables, multiplier stages,
// pipelined divider and output register. Depends on dsc_pkg and dsc_if.
//
//   channel   role    handshake                     content
//   in_ch     sink    valid/ready                   load or compute item
//   out_ch    source  valid/ready                   four coefficients and status
//   cfg_*     slave   psel/penable/pwrite, pready=1 columns_in_use, rows_in_use
//
// One item enters every cycle unless the output stalls. Each item passes six table and
// multiplier stages, then the 47 one-bit stages of the restoring divider.
// Reset is synchronous and active low; it clears the valid bits and config registers.
// The tables are not cleared: an entry reads as garbage until it is written.
// The pipeline advances as a whole whenever the output register is empty or taken, so
// a stall at the output freezes every stage and loses no item.
`timescale 1ns / 1ps

module diffusion_stencil_coefficients (
  input  logic                       clk,
  input  logic                       rst_n,
  dsc_in_if.sink                     in_ch,
  dsc_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dsc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dsc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dsc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import dsc_pkg::*;

  // Divider step: shift the partial remainder, subtract the divisor if it fits.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic [DEN_W-1:0] den);
    logic [REM_W-1:0] sh;
    logic             ge;
    sh = {rem[REM_W-2:0], 1'b0};
    ge = (sh >= REM_W'(den));
    div_step = {(ge ? sh - REM_W'(den) : sh), ge};
  endfunction

  // Sigma row is the zero-based material, column the zero-based group.
  function automatic logic [SIG_AW-1:0] sig_addr(input logic [MID_W-1:0] id,
                                                 input logic [GRP_BITS-1:0] grp);
    logic [MID_W-1:0] idm1;
    idm1 = id - MID_W'(1);
    sig_addr = {idm1[MAT_BITS-1:0], grp};
  endfunction

  // ------------------------------------------------------------------
  // Configuration registers. Register select is the word address bit.
  // ------------------------------------------------------------------
  logic [COLS_CFG_W-1:0] columns_r;
  logic [ROWS_CFG_W-1:0] rows_r;
  logic                  cfg_wr;
  logic                  cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_paddr[CFG_AW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_ROWS) begin
        rows_r <= cfg_pwdata[ROWS_CFG_W-1:0];
      end else begin
        columns_r <= cfg_pwdata[COLS_CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_COLUMNS: cfg_prdata = CFG_DW'(columns_r);
      REG_ROWS:    cfg_prdata = CFG_DW'(rows_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshake. Every stage register moves when adv is high.
  // ------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic accept;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // ------------------------------------------------------------------
  // Table writes happen when a load item is accepted. Reads are registered
  // and return the old contents, so a load always lands after every item
  // accepted before it has made its reads.
  // ------------------------------------------------------------------
  logic                we_sig, we_map, we_rad, we_ax;
  logic [SIG_AW-1:0]   sig_waddr;
  logic [GROUP_W-1:0]  grp_m1;

  assign grp_m1    = in_ch.group - GROUP_W'(1);
  assign sig_waddr = sig_addr(in_ch.material_id, grp_m1[GRP_BITS-1:0]);
  assign we_sig    = accept && (in_ch.op == OP_LOAD_SIGMA) && (in_ch.material_id != '0);
  assign we_map    = accept && (in_ch.op == OP_LOAD_MAT);
  assign we_rad    = accept && (in_ch.op == OP_LOAD_RAD) &&
                     (int'(in_ch.table_address) < RAD_DEPTH);
  assign we_ax     = accept && (in_ch.op == OP_LOAD_AX) &&
                     (int'(in_ch.table_address) < AX_DEPTH);

  // Stage 0: decode, edge tests, map and width reads.
  logic [MAP_AW-1:0] cell_addr, nb_e, nb_w, nb_n, nb_s, step;
  logic [NDIR-1:0]   inner_nxt;
  ctrl_t             s0_ctrl_nxt;

  assign cell_addr = in_ch.cell_index[MAP_AW-1:0];
  assign step      = MAP_AW'(columns_r);
  assign nb_e      = cell_addr + MAP_AW'(1);
  assign nb_w      = cell_addr - MAP_AW'(1);
  assign nb_n      = cell_addr + step;
  assign nb_s      = cell_addr - step;

  always_comb begin
    inner_nxt[DIR_E] = (COLS_CFG_W'(in_ch.column) + COLS_CFG_W'(1)) < columns_r;
    inner_nxt[DIR_W] = (in_ch.column != '0);
    inner_nxt[DIR_N] = (ROWS_CFG_W'(in_ch.row) + ROWS_CFG_W'(1)) < rows_r;
    inner_nxt[DIR_S] = (in_ch.row != '0);
  end

  always_comb begin
    s0_ctrl_nxt = '{compute: 1'b0, status: ST_OK};
    case (op_t'(in_ch.op))
      OP_LOAD_SIGMA: s0_ctrl_nxt.status = (in_ch.material_id == '0) ? ST_ID_ZERO : ST_WRITTEN;
      OP_LOAD_MAT:   s0_ctrl_nxt.status = ST_WRITTEN;
      OP_LOAD_RAD:   s0_ctrl_nxt.status = ST_WRITTEN;
      OP_LOAD_AX:    s0_ctrl_nxt.status = ST_WRITTEN;
      OP_COMPUTE:    s0_ctrl_nxt.compute = 1'b1;
      default:       s0_ctrl_nxt.status = ST_OK;
    endcase
  end

  logic                s0_v_r;
  ctrl_t               s0_ctrl_r;
  logic [GRP_BITS-1:0] s0_grp_r;
  logic [NDIR-1:0]     s0_inner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctrl_r  <= s0_ctrl_nxt;
      s0_grp_r   <= grp_m1[GRP_BITS-1:0];
      s0_inner_r <= inner_nxt;
    end
  end

  // Material map: three copies so that the cell and its four neighbors are read
  // in the same cycle.
  logic [MID_W-1:0] map0_mem [MAP_DEPTH];
  logic [MID_W-1:0] map1_mem [MAP_DEPTH];
  logic [MID_W-1:0] map2_mem [MAP_DEPTH];
  logic [MID_W-1:0] own_id_r;
  logic [MID_W-1:0] nb_id_r [NDIR];

  always_ff @(posedge clk) begin
    if (we_map) map0_mem[cell_addr] <= in_ch.material_id;
    if (adv) begin
      own_id_r       <= map0_mem[cell_addr];
      nb_id_r[DIR_E] <= map0_mem[nb_e];
    end
  end

  always_ff @(posedge clk) begin
    if (we_map) map1_mem[cell_addr] <= in_ch.material_id;
    if (adv) begin
      nb_id_r[DIR_W] <= map1_mem[nb_w];
      nb_id_r[DIR_N] <= map1_mem[nb_n];
    end
  end

  always_ff @(posedge clk) begin
    if (we_map) map2_mem[cell_addr] <= in_ch.material_id;
    if (adv) nb_id_r[DIR_S] <= map2_mem[nb_s];
  end

  // Width tables, two copies each. Index 0 and the last index are the ghosts.
  logic [VAL_W-1:0]  rad0_mem [RAD_DEPTH];
  logic [VAL_W-1:0]  rad1_mem [RAD_DEPTH];
  logic [VAL_W-1:0]  ax0_mem  [AX_DEPTH];
  logic [VAL_W-1:0]  ax1_mem  [AX_DEPTH];
  logic [VAL_W-1:0]  d_rad_r, d_ax_r;
  logic [VAL_W-1:0]  dn_r [NDIR];
  logic [RAD_AW-1:0] rad_waddr, rad_i;
  logic [AX_AW-1:0]  ax_waddr, ax_i;

  assign rad_waddr = in_ch.table_address[RAD_AW-1:0];
  assign ax_waddr  = in_ch.table_address[AX_AW-1:0];
  assign rad_i     = RAD_AW'(in_ch.column);
  assign ax_i      = AX_AW'(in_ch.row);

  always_ff @(posedge clk) begin
    if (we_rad) rad0_mem[rad_waddr] <= in_ch.value;
    if (adv) begin
      d_rad_r     <= rad0_mem[rad_i + RAD_AW'(1)];
      dn_r[DIR_W] <= rad0_mem[rad_i];
    end
  end

  always_ff @(posedge clk) begin
    if (we_rad) rad1_mem[rad_waddr] <= in_ch.value;
    if (adv) dn_r[DIR_E] <= rad1_mem[rad_i + RAD_AW'(2)];
  end

  always_ff @(posedge clk) begin
    if (we_ax) ax0_mem[ax_waddr] <= in_ch.value;
    if (adv) begin
      d_ax_r      <= ax0_mem[ax_i + AX_AW'(1)];
      dn_r[DIR_S] <= ax0_mem[ax_i];
    end
  end

  always_ff @(posedge clk) begin
    if (we_ax) ax1_mem[ax_waddr] <= in_ch.value;
    if (adv) dn_r[DIR_N] <= ax1_mem[ax_i + AX_AW'(2)];
  end

  // ------------------------------------------------------------------
  // Stage 1: material ids, id-zero check, sigma reads, width products.
  // A boundary neighbor takes the cell's own material.
  // ------------------------------------------------------------------
  logic [MID_W-1:0] id_c [NDIR];
  logic             idzero;
  ctrl_t            s1_ctrl_nxt;

  always_comb begin
    idzero = (own_id_r == '0);
    for (int k = 0; k < NDIR; k++) begin
      id_c[k] = s0_inner_r[k] ? nb_id_r[k] : own_id_r;
      if (id_c[k] == '0) idzero = 1'b1;
    end
    s1_ctrl_nxt = s0_ctrl_r;
    if (s0_ctrl_r.compute && idzero) begin
      s1_ctrl_nxt.compute = 1'b0;
      s1_ctrl_nxt.status  = ST_ID_ZERO;
    end
  end

  logic              s1_v_r;
  ctrl_t             s1_ctrl_r;
  logic [NDIR-1:0]   s1_inner_r;
  logic [PROD_W-1:0] dd_r  [2];
  logic [PROD_W-1:0] ddn_r [NDIR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl_r  <= s1_ctrl_nxt;
      s1_inner_r <= s0_inner_r;
      dd_r[0]    <= PROD_W'(d_rad_r) * PROD_W'(d_rad_r);
      dd_r[1]    <= PROD_W'(d_ax_r) * PROD_W'(d_ax_r);
      ddn_r[DIR_E] <= PROD_W'(d_rad_r) * PROD_W'(dn_r[DIR_E]);
      ddn_r[DIR_W] <= PROD_W'(d_rad_r) * PROD_W'(dn_r[DIR_W]);
      ddn_r[DIR_N] <= PROD_W'(d_ax_r) * PROD_W'(dn_r[DIR_N]);
      ddn_r[DIR_S] <= PROD_W'(d_ax_r) * PROD_W'(dn_r[DIR_S]);
    end
  end

  // Sigma store: three copies, own sigma plus four neighbor sigmas per cycle.
  logic [VAL_W-1:0] sig0_mem [SIGMA_DEPTH];
  logic [VAL_W-1:0] sig1_mem [SIGMA_DEPTH];
  logic [VAL_W-1:0] sig2_mem [SIGMA_DEPTH];
  logic [VAL_W-1:0] sig_own_r;
  logic [VAL_W-1:0] sig_nb_r [NDIR];

  always_ff @(posedge clk) begin
    if (we_sig) sig0_mem[sig_waddr] <= in_ch.value;
    if (adv) begin
      sig_own_r       <= sig0_mem[sig_addr(own_id_r, s0_grp_r)];
      sig_nb_r[DIR_E] <= sig0_mem[sig_addr(id_c[DIR_E], s0_grp_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (we_sig) sig1_mem[sig_waddr] <= in_ch.value;
    if (adv) begin
      sig_nb_r[DIR_W] <= sig1_mem[sig_addr(id_c[DIR_W], s0_grp_r)];
      sig_nb_r[DIR_N] <= sig1_mem[sig_addr(id_c[DIR_N], s0_grp_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (we_sig) sig2_mem[sig_waddr] <= in_ch.value;
    if (adv) sig_nb_r[DIR_S] <= sig2_mem[sig_addr(id_c[DIR_S], s0_grp_r)];
  end

  // ------------------------------------------------------------------
  // Stage 2: 64 by 32 products as two 32 by 32 partial products each.
  // ------------------------------------------------------------------
  logic [VAL_W-1:0]  sn_c [NDIR];
  logic              s2_v_r;
  ctrl_t             s2_ctrl_r;
  logic [PROD_W-1:0] ph_r [NDIR];
  logic [PROD_W-1:0] pl_r [NDIR];
  logic [PROD_W-1:0] uh_r [2];
  logic [PROD_W-1:0] ul_r [2];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      sn_c[k] = s1_inner_r[k] ? sig_nb_r[k] : sig_own_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctrl_r <= s1_ctrl_r;
      for (int k = 0; k < NDIR; k++) begin
        ph_r[k] <= PROD_W'(ddn_r[k][PROD_W-1:VAL_W]) * PROD_W'(sn_c[k]);
        pl_r[k] <= PROD_W'(ddn_r[k][VAL_W-1:0]) * PROD_W'(sn_c[k]);
      end
      for (int j = 0; j < 2; j++) begin
        uh_r[j] <= PROD_W'(dd_r[j][PROD_W-1:VAL_W]) * PROD_W'(sig_own_r);
        ul_r[j] <= PROD_W'(dd_r[j][VAL_W-1:0]) * PROD_W'(sig_own_r);
      end
    end
  end

  // Stage 3: assemble the 96-bit triple products.
  logic              s3_v_r;
  ctrl_t             s3_ctrl_r;
  logic [TRIP_W-1:0] t_r [NDIR];
  logic [TRIP_W-1:0] u_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctrl_r <= s2_ctrl_r;
      for (int k = 0; k < NDIR; k++) begin
        t_r[k] <= (TRIP_W'(ph_r[k]) << VAL_W) + TRIP_W'(pl_r[k]);
      end
      for (int j = 0; j < 2; j++) begin
        u_r[j] <= (TRIP_W'(uh_r[j]) << VAL_W) + TRIP_W'(ul_r[j]);
      end
    end
  end

  // Stage 4: S = d*dn*sigma_n + d*d*sigma_p. East and west use the radial own term.
  logic             s4_v_r;
  ctrl_t            s4_ctrl_r;
  logic [SUM_W-1:0] s_r [NDIR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctrl_r <= s3_ctrl_r;
      for (int k = 0; k < NDIR; k++) begin
        s_r[k] <= SUM_W'(t_r[k]) + SUM_W'(u_r[k / 2]);
      end
    end
  end

  // Stage 5: divisor 3*S, which carries 48 fraction bits.
  logic             s5_v_r;
  ctrl_t            s5_ctrl_r;
  logic [DEN_W-1:0] den_r [NDIR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ctrl_r <= s4_ctrl_r;
      for (int k = 0; k < NDIR; k++) begin
        den_r[k] <= DEN_W'(s_r[k]) + (DEN_W'(s_r[k]) << 1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Divider: floor(2^81 / den), one quotient bit per stage, most significant
  // first. The quotient fits in 47 bits exactly when den exceeds 2^34, so the
  // remainder starts at 2^34 (the dividend bits above the quotient). Smaller
  // divisors saturate, and a zero divisor also raises the status flag.
  // ------------------------------------------------------------------
  logic             div_v_r    [DIV_STEPS];
  ctrl_t            div_ctrl_r [DIV_STEPS];
  logic [DEN_W-1:0] div_den_r  [DIV_STEPS][NDIR];
  logic [REM_W-1:0] div_rem_r  [DIV_STEPS][NDIR];
  logic [Q_W-1:0]   div_q_r    [DIV_STEPS][NDIR];
  logic             div_zf_r   [DIV_STEPS][NDIR];
  logic             div_sf_r   [DIV_STEPS][NDIR];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic             v_in;
    ctrl_t            ctrl_in;
    logic [DEN_W-1:0] den_in [NDIR];
    logic [REM_W-1:0] rem_in [NDIR];
    logic [Q_W-1:0]   q_in   [NDIR];
    logic             zf_in  [NDIR];
    logic             sf_in  [NDIR];
    logic [REM_W:0]   st     [NDIR];

    if (j == 0) begin : g_first
      always_comb begin
        v_in    = s5_v_r;
        ctrl_in = s5_ctrl_r;
        for (int k = 0; k < NDIR; k++) begin
          den_in[k] = den_r[k];
          rem_in[k] = DIV_INIT;
          q_in[k]   = '0;
          zf_in[k]  = (den_r[k] == '0);
          sf_in[k]  = (den_r[k] <= SAT_DEN);
        end
      end
    end else begin : g_next
      always_comb begin
        v_in    = div_v_r[j-1];
        ctrl_in = div_ctrl_r[j-1];
        for (int k = 0; k < NDIR; k++) begin
          den_in[k] = div_den_r[j-1][k];
          rem_in[k] = div_rem_r[j-1][k];
          q_in[k]   = div_q_r[j-1][k];
          zf_in[k]  = div_zf_r[j-1][k];
          sf_in[k]  = div_sf_r[j-1][k];
        end
      end
    end

    always_comb begin
      for (int k = 0; k < NDIR; k++) begin
        st[k] = div_step(rem_in[k], den_in[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[j] <= 1'b0;
      end else if (adv) begin
        div_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_ctrl_r[j] <= ctrl_in;
        for (int k = 0; k < NDIR; k++) begin
          div_den_r[j][k] <= den_in[k];
          div_rem_r[j][k] <= st[k][REM_W:1];
          div_q_r[j][k]   <= {q_in[k][Q_W-2:0], st[k][0]};
          div_zf_r[j][k]  <= zf_in[k];
          div_sf_r[j][k]  <= sf_in[k];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Output register: negate the magnitude, apply saturation and status.
  // ------------------------------------------------------------------
  logic [COEF_W-1:0] coef_nxt [NDIR];
  status_t           status_nxt;
  logic [COEF_W-1:0] coef_r [NDIR];
  status_t           status_r;

  always_comb begin
    logic any_zero;
    any_zero = 1'b0;
    for (int k = 0; k < NDIR; k++) begin
      if (!div_ctrl_r[DIV_STEPS-1].compute) begin
        coef_nxt[k] = '0;
      end else if (div_sf_r[DIV_STEPS-1][k]) begin
        coef_nxt[k] = SAT_COEF;
      end else begin
        coef_nxt[k] = COEF_W'(0) - COEF_W'(div_q_r[DIV_STEPS-1][k]);
      end
      if (div_zf_r[DIV_STEPS-1][k]) any_zero = 1'b1;
    end
    if (div_ctrl_r[DIV_STEPS-1].compute) begin
      status_nxt = any_zero ? ST_ZERO_DEN : ST_OK;
    end else begin
      status_nxt = div_ctrl_r[DIV_STEPS-1].status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coef_r   <= coef_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coef_east  = $signed(coef_r[DIR_E]);
  assign out_ch.coef_west  = $signed(coef_r[DIR_W]);
  assign out_ch.coef_north = $signed(coef_r[DIR_N]);
  assign out_ch.coef_south = $signed(coef_r[DIR_S]);
  assign out_ch.status     = status_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  // A zero denominator always shows up as a saturated coefficient.
  a_zero_den_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_ZERO_DEN) |->
      (coef_r[DIR_E] == SAT_COEF) || (coef_r[DIR_W] == SAT_COEF) ||
      (coef_r[DIR_N] == SAT_COEF) || (coef_r[DIR_S] == SAT_COEF))
    else $error("zero denominator status without a saturated coefficient");

  // Loads and id-zero results carry no coefficients.
  a_no_coef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((status_r == ST_WRITTEN) || (status_r == ST_ID_ZERO)) |->
      (coef_r[DIR_E] == '0) && (coef_r[DIR_W] == '0) &&
      (coef_r[DIR_N] == '0) && (coef_r[DIR_S] == '0))
    else $error("coefficients present on a load or id-zero item");

  // A waiting result blocks the pipeline: no item may enter over it, and the last
  // divider stage holds its item through the stalled cycle.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready ##1 $stable(div_v_r[DIV_STEPS-1]))
    else $error("pipeline advanced while the output was stalled");

endmodule
